// File: sv/fl_ptw_pkg.sv
// Shared types, constants and address helpers of the page-table walker.
package fl_ptw_pkg;

  localparam int unsigned MEM_WORDS_LOG2 = 12;
  localparam int unsigned PHYS_ADDR_BITS = 52;

  localparam logic [63:0] PHYS_MASK   = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
  localparam logic [63:0] FRAME_MASK  = PHYS_MASK & ~64'hFFF;
  localparam logic [63:0] PRESENT_BIT = 64'h1;
  localparam logic [63:0] WRITE_BIT   = 64'h2;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_XLAT   = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;

  typedef logic [MEM_WORDS_LOG2-1:0] word_addr_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [51:0] root_table_addr;
    logic [47:0] virt_addr;
    logic        make_read_only;
    logic [11:0] word_index;
    logic [63:0] word_data;
  } item_t;

  typedef struct packed {
    logic [51:0] phys_addr;
    logic        ok;
  } result_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_IN,
    RD_NEXT
  } rd_src_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_IN,
    WR_LEAF,
    WR_CLEAR
  } wr_src_e;

  typedef enum logic [1:0] {
    RES_MISS,
    RES_DONE,
    RES_XLAT
  } res_kind_e;

  typedef struct packed {
    logic       latch;
    rd_src_e    rd_src;
    logic [1:0] level;
    wr_src_e    wr_src;
    word_addr_t clr_addr;
    logic       res_load;
    res_kind_e  res_kind;
  } cmd_t;

  typedef struct packed {
    logic present;
  } status_t;

  function automatic logic [8:0] level_index(input logic [47:0] va, input logic [1:0] level);
    logic [8:0] idx;
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic word_addr_t entry_slot(input logic [63:0] tbl, input logic [8:0] idx);
    logic [63:0] sum;
    sum = ((tbl & FRAME_MASK) >> 3) + 64'(idx);
    return sum[MEM_WORDS_LOG2-1:0];
  endfunction

endpackage

// File: sv/four_level_page_table_walker.sv
// Top level of the four-level page-table walker.
// After reset the block sweeps its 4096-word table memory to zero, one word a cycle,
// and holds busy_o high until the sweep is done. An item is taken when start_i is high
// and busy_o is low; its result beat appears on result_o with done_o high for one cycle
// and cannot be held off. A table write or an unused code returns its beat in the cycle
// after it is taken and leaves busy_o low. A translate reads one table level per cycle
// through the single memory read port and ends early on an entry that is not present;
// a modify of the writable bit adds a write-back step after the leaf entry is read.
module four_level_page_table_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  fl_ptw_pkg::item_t   in_i,
  output logic                busy_o,
  output logic                done_o,
  output fl_ptw_pkg::result_t result_o
);

  fl_ptw_pkg::cmd_t    cmd;
  fl_ptw_pkg::status_t status;

  fl_ptw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (in_i.func),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  fl_ptw_dp u_dp (
    .clk_i   (clk_i),
    .in_i    (in_i),
    .cmd_i   (cmd),
    .status_o(status),
    .result_o(result_o)
  );

endmodule

// File: sv/fl_ptw_dp.sv
// Datapath of the page-table walker: table memory, item and result registers.
module fl_ptw_dp (
  input  logic                clk_i,
  input  fl_ptw_pkg::item_t   in_i,
  input  fl_ptw_pkg::cmd_t    cmd_i,
  output fl_ptw_pkg::status_t status_o,
  output fl_ptw_pkg::result_t result_o
);

  logic [63:0] mem [2**fl_ptw_pkg::MEM_WORDS_LOG2];

  logic [63:0]             rdata_q;
  fl_ptw_pkg::word_addr_t  slot_q;
  logic [47:0]             va_q;
  logic                    ro_q;
  fl_ptw_pkg::result_t     res_q;

  logic                    rd_en;
  fl_ptw_pkg::word_addr_t  rd_addr;
  logic                    wr_en;
  fl_ptw_pkg::word_addr_t  wr_addr;
  logic [63:0]             wr_data;
  logic [63:0]             widx_ext;
  logic [63:0]             phys_full;
  fl_ptw_pkg::result_t     res_d;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (cmd_i.rd_src)
      fl_ptw_pkg::RD_IN: begin
        rd_en   = 1'b1;
        rd_addr = fl_ptw_pkg::entry_slot(64'(in_i.root_table_addr),
                    fl_ptw_pkg::level_index(in_i.virt_addr, cmd_i.level));
      end
      fl_ptw_pkg::RD_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = fl_ptw_pkg::entry_slot(rdata_q,
                    fl_ptw_pkg::level_index(va_q, cmd_i.level));
      end
      default: ;
    endcase
  end

  assign widx_ext = 64'(in_i.word_index);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (cmd_i.wr_src)
      fl_ptw_pkg::WR_IN: begin
        wr_en   = 1'b1;
        wr_addr = widx_ext[fl_ptw_pkg::MEM_WORDS_LOG2-1:0];
        wr_data = in_i.word_data;
      end
      fl_ptw_pkg::WR_LEAF: begin
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_data = ro_q ? (rdata_q & ~fl_ptw_pkg::WRITE_BIT)
                       : (rdata_q | fl_ptw_pkg::WRITE_BIT);
      end
      fl_ptw_pkg::WR_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cmd_i.clr_addr;
        wr_data = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      slot_q  <= rd_addr;
    end
  end

  assign phys_full = (rdata_q & fl_ptw_pkg::FRAME_MASK) | 64'(va_q[11:0]);

  always_comb begin
    res_d = '0;
    case (cmd_i.res_kind)
      fl_ptw_pkg::RES_DONE: res_d.ok = 1'b1;
      fl_ptw_pkg::RES_XLAT: begin
        res_d.phys_addr = phys_full[51:0];
        res_d.ok        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      va_q <= in_i.virt_addr;
      ro_q <= in_i.make_read_only;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
  end

  assign status_o.present = |(rdata_q & fl_ptw_pkg::PRESENT_BIT);
  assign result_o         = res_q;

endmodule

// File: sv/fl_ptw_ctrl.sv
// Controller of the page-table walker: clear sweep, walk sequencing, result strobe.
module fl_ptw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          func_i,
  input  fl_ptw_pkg::status_t status_i,
  output fl_ptw_pkg::cmd_t    cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_WB    = 2'd3;

  localparam fl_ptw_pkg::word_addr_t CLR_LAST = '1;

  logic [1:0]             state_q, state_d;
  logic [1:0]             level_q, level_d;
  logic                   mod_q, mod_d;
  logic                   done_q, done_d;
  fl_ptw_pkg::word_addr_t clr_q, clr_d;

  always_comb begin
    state_d = state_q;
    level_d = level_q;
    mod_d   = mod_q;
    clr_d   = clr_q;
    done_d  = 1'b0;
    cmd_o   = '{latch: 1'b0, rd_src: fl_ptw_pkg::RD_NONE, level: 2'd0,
                wr_src: fl_ptw_pkg::WR_NONE, clr_addr: clr_q, res_load: 1'b0,
                res_kind: fl_ptw_pkg::RES_MISS};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_src = fl_ptw_pkg::WR_CLEAR;
        clr_d        = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            fl_ptw_pkg::FUNC_WRITE: begin
              cmd_o.wr_src   = fl_ptw_pkg::WR_IN;
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = fl_ptw_pkg::RES_DONE;
              done_d         = 1'b1;
            end
            fl_ptw_pkg::FUNC_XLAT, fl_ptw_pkg::FUNC_MODIFY: begin
              cmd_o.latch  = 1'b1;
              cmd_o.rd_src = fl_ptw_pkg::RD_IN;
              level_d      = 2'd0;
              mod_d        = (func_i == fl_ptw_pkg::FUNC_MODIFY);
              state_d      = S_WALK;
            end
            default: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = fl_ptw_pkg::RES_MISS;
              done_d         = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if (!status_i.present) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = fl_ptw_pkg::RES_MISS;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else if (level_q == 2'd3) begin
          if (mod_q) begin
            state_d = S_WB;
          end else begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = fl_ptw_pkg::RES_XLAT;
            done_d         = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.rd_src = fl_ptw_pkg::RD_NEXT;
          cmd_o.level  = level_q + 2'd1;
          level_d      = level_q + 2'd1;
        end
      end
      S_WB: begin
        cmd_o.wr_src   = fl_ptw_pkg::WR_LEAF;
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = fl_ptw_pkg::RES_DONE;
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      level_q <= 2'd0;
      mod_q   <= 1'b0;
      done_q  <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      mod_q   <= mod_d;
      done_q  <= done_d;
      clr_q   <= clr_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
